/* src/sfpq_pkg.sv */
// Package: shared types and constants for the servo frame parser queue.
package sfpq_pkg;

  localparam logic [7:0] SYNC_BYTE      = 8'h55;
  localparam logic [7:0] LEN_MIN_BOARD  = 8'd2;
  localparam logic [7:0] LEN_MAX_BOARD  = 8'd64;
  localparam logic [7:0] LEN_MIN_DIRECT = 8'd3;
  localparam logic [7:0] LEN_MAX_DIRECT = 8'd11;
  localparam logic [7:0] BASE_BOARD     = 8'd2;
  localparam logic [7:0] BASE_DIRECT    = 8'd3;
  localparam int unsigned MAX_PARAMS    = 8;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_ID      = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_COMMAND = 3'd3,
    PH_PARAMS  = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [63:0] params;
    logic [3:0]  count;
    logic [7:0]  command;
    logic [7:0]  length;
    logic [7:0]  id;
  } entry_t;

  typedef struct packed {
    logic   en;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic pop;
    logic clear;
  } qctl_t;

endpackage

/* src/sfpq_ram.sv */
// Generic single-port-write, registered-read RAM.
module sfpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/sfpq_parser.sv */
// Frame parser: header search, field capture, running checksum.
module sfpq_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           mode,
  input  logic           restart,
  input  logic           byte_en,
  input  logic [7:0]     data_byte,
  output sfpq_pkg::push_t push
);
  import sfpq_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [63:0] params_r, params_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        push_en;

  logic [7:0]  ptotal;
  logic [7:0]  sum_add;
  logic        len_ok;
  logic        param_ok;
  logic        param_last;
  logic        check_ok;

  assign ptotal     = length_r - (mode ? BASE_DIRECT : BASE_BOARD);
  assign sum_add    = sum_r + data_byte;
  assign len_ok     = mode ? (data_byte >= LEN_MIN_DIRECT && data_byte <= LEN_MAX_DIRECT)
                           : (data_byte >= LEN_MIN_BOARD && data_byte <= LEN_MAX_BOARD);
  assign param_ok   = ({4'd0, idx_r} < ptotal) && (idx_r < 4'(MAX_PARAMS));
  assign param_last = (({4'd0, idx_r} + 8'd1) >= ptotal);
  assign check_ok   = (~sum_r == data_byte);

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    case (phase_r)
      PH_HEADER: begin
        if (idx_r == 4'd0) begin
          if (data_byte == SYNC_BYTE) idx_nxt = 4'd1;
        end else if (data_byte == SYNC_BYTE) begin
          idx_nxt   = 4'd0;
          phase_nxt = mode ? PH_ID : PH_LENGTH;
        end else begin
          idx_nxt = 4'd0;
        end
      end
      PH_ID: begin
        phase_nxt = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (len_ok) begin
          phase_nxt = PH_COMMAND;
        end else begin
          phase_nxt = PH_HEADER;
          idx_nxt   = 4'd0;
        end
      end
      PH_COMMAND: begin
        idx_nxt = 4'd0;
        if (ptotal != 8'd0) phase_nxt = PH_PARAMS;
        else if (mode)      phase_nxt = PH_CHECK;
        else                phase_nxt = PH_HEADER;
      end
      PH_PARAMS: begin
        if (param_ok) begin
          idx_nxt = idx_r + 4'd1;
          if (param_last) begin
            phase_nxt = mode ? PH_CHECK : PH_HEADER;
            idx_nxt   = 4'd0;
          end
        end else begin
          phase_nxt = PH_HEADER;
          idx_nxt   = 4'd0;
        end
      end
      PH_CHECK: begin
        phase_nxt = PH_HEADER;
        idx_nxt   = 4'd0;
      end
      default: begin
        phase_nxt = PH_HEADER;
        idx_nxt   = 4'd0;
      end
    endcase
  end

  always_comb begin
    id_nxt     = id_r;
    length_nxt = length_r;
    cmd_nxt    = cmd_r;
    params_nxt = params_r;
    sum_nxt    = sum_r;
    push_en    = 1'b0;
    case (phase_r)
      PH_HEADER: begin
        if (idx_r != 4'd0 && data_byte == SYNC_BYTE) begin
          id_nxt     = 8'd0;
          length_nxt = 8'd0;
          cmd_nxt    = 8'd0;
          params_nxt = 64'd0;
          sum_nxt    = 8'd0;
        end
      end
      PH_ID: begin
        id_nxt  = data_byte;
        sum_nxt = sum_add;
      end
      PH_LENGTH: begin
        length_nxt = data_byte;
        sum_nxt    = sum_add;
      end
      PH_COMMAND: begin
        cmd_nxt = data_byte;
        sum_nxt = sum_add;
        push_en = (ptotal == 8'd0) && !mode;
      end
      PH_PARAMS: begin
        if (param_ok) begin
          params_nxt = params_r | (64'(data_byte) << {idx_r[2:0], 3'b000});
          sum_nxt    = sum_add;
          push_en    = param_last && !mode;
        end
      end
      PH_CHECK: begin
        push_en = check_ok;
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      phase_r  <= PH_HEADER;
      idx_r    <= 4'd0;
      id_r     <= 8'd0;
      length_r <= 8'd0;
      cmd_r    <= 8'd0;
      params_r <= 64'd0;
      sum_r    <= 8'd0;
    end else if (byte_en) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      id_r     <= id_nxt;
      length_r <= length_nxt;
      cmd_r    <= cmd_nxt;
      params_r <= params_nxt;
      sum_r    <= sum_nxt;
    end
  end

  always_comb begin
    push.en           = byte_en && push_en;
    push.entry.id     = id_nxt;
    push.entry.length = length_nxt;
    push.entry.command = cmd_nxt;
    push.entry.count  = ptotal[3:0];
    push.entry.params = params_nxt;
  end

endmodule

/* src/sfpq_queue.sv */
// Packet FIFO: pointers, entry RAM and the pop result register.
module sfpq_queue #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             restart,
  input  sfpq_pkg::push_t  push,
  input  sfpq_pkg::qctl_t  ctl,
  output logic             pop_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_packet_valid,
  output logic [7:0]       out_servo_id,
  output logic [7:0]       out_frame_length,
  output logic [7:0]       out_command,
  output logic [3:0]       out_param_count,
  output logic [63:0]      out_param_bytes,
  output logic [3:0]       out_packets_left
);
  import sfpq_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LW = (CW > 4) ? CW : 4;
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          o_v_r;
  logic          o_pkt_r;
  logic [3:0]    o_left_r;

  logic          do_push;
  logic          do_read;
  logic [CW-1:0] left_w;
  logic [LW-1:0] left_ext;
  entry_t        rd_entry;
  logic [$bits(entry_t)-1:0] rd_bits;

  assign do_push  = push.en && (count_r != FULL);
  assign do_read  = ctl.pop && (count_r != '0);
  assign left_w   = count_r - CW'(1);
  assign left_ext = LW'(left_w);
  assign pop_ready = !o_v_r || out_ready;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (do_push) begin
      head_nxt  = (head_r == LAST) ? '0 : head_r + AW'(1);
      count_nxt = count_r + CW'(1);
    end else if (do_read) begin
      tail_nxt  = (tail_r == LAST) ? '0 : tail_r + AW'(1);
      count_nxt = left_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (ctl.pop) begin
      o_v_r <= 1'b1;
    end else if (out_ready) begin
      o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      o_pkt_r  <= do_read;
      o_left_r <= do_read ? left_ext[3:0] : 4'd0;
    end
  end

  sfpq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_push && !ctl.clear),
    .waddr (head_r),
    .wdata (push.entry),
    .re    (do_read),
    .raddr (tail_r),
    .rdata (rd_bits)
  );

  assign rd_entry = o_pkt_r ? entry_t'(rd_bits) : '0;

  assign out_valid        = o_v_r;
  assign out_packet_valid = o_pkt_r;
  assign out_servo_id     = rd_entry.id;
  assign out_frame_length = rd_entry.length;
  assign out_command      = rd_entry.command;
  assign out_param_count  = rd_entry.count;
  assign out_param_bytes  = rd_entry.params;
  assign out_packets_left = o_left_r;

endmodule

/* src/servo_frame_parser_queue_core.sv */
// Top level: input register, frame parser and packet FIFO with pop result register.
//
//   channel  | ports                               | handshake
//   ---------+-------------------------------------+------------------------
//   input    | in_kind, in_data_byte               | in_valid / in_ready
//   result   | out_packet_valid .. out_packets_left| out_valid / out_ready
//   config   | cfg_wdata (frame_mode)              | cfg_we, no wait
//
// One beat per cycle while in_ready is high. A beat is held in the input
// register, where it is parsed or applied to the FIFO; a pop result appears
// in the following cycle from the RAM read register. Only a pop waiting on a
// stalled result holds the input register and drops in_ready. Reset is
// synchronous and needs no clearing pass; unpopped FIFO entries are never read.
module servo_frame_parser_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_packet_valid,
  output logic [7:0]  out_servo_id,
  output logic [7:0]  out_frame_length,
  output logic [7:0]  out_command,
  output logic [3:0]  out_param_count,
  output logic [63:0] out_param_bytes,
  output logic [3:0]  out_packets_left
);
  import sfpq_pkg::*;

  logic       mode_r;
  logic       s1_v_r;
  logic [1:0] s1_kind_r;
  logic [7:0] s1_byte_r;
  logic       s1_adv;
  logic       pop_ready;
  push_t      push;
  qctl_t      qctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  assign s1_adv   = s1_v_r && (s1_kind_r != KIND_POP || pop_ready);
  assign in_ready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_data_byte;
    end
  end

  always_comb begin
    qctl.pop   = s1_adv && (s1_kind_r == KIND_POP);
    qctl.clear = (s1_v_r && (s1_kind_r == KIND_CLEAR)) || cfg_we;
  end

  sfpq_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .restart   (cfg_we),
    .byte_en   (s1_v_r && (s1_kind_r == KIND_BYTE)),
    .data_byte (s1_byte_r),
    .push      (push)
  );

  sfpq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk              (clk),
    .rst_n            (rst_n),
    .restart          (cfg_we),
    .push             (push),
    .ctl              (qctl),
    .pop_ready        (pop_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_packet_valid (out_packet_valid),
    .out_servo_id     (out_servo_id),
    .out_frame_length (out_frame_length),
    .out_command      (out_command),
    .out_param_count  (out_param_count),
    .out_param_bytes  (out_param_bytes),
    .out_packets_left (out_packets_left)
  );

  a_stall_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_v_r && s1_kind_r == KIND_POP && out_valid && !out_ready)
    else $error("input stalled without a blocked pop");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_packet_valid |->
      out_servo_id == 8'd0 && out_command == 8'd0 && out_param_bytes == 64'd0 &&
      out_packets_left == 4'd0)
    else $error("empty pop carries data");

  a_param_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_valid |-> out_param_count <= 4'(MAX_PARAMS))
    else $error("packet with too many parameters");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_kind_r == KIND_POP && pop_ready && !cfg_we |=> out_valid)
    else $error("pop gave no result");

endmodule
